/* rtl/lpsk_pkg.sv */
// shared constants for the low-pass plus scalar kalman block
// no dependencies; imported by every rtl module of the block
`default_nettype none

package lpsk_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int Q16_W      = 32;   // signed q16.16 values
  localparam int GAIN_W     = 25;   // unsigned q1.24 gain, 0..2^24
  localparam int WEIGHT_W   = 10;
  localparam int NOISE_W    = 24;
  localparam int COV_CFG_W  = 28;
  localparam int COV_W      = 32;   // unsigned q8.24 covariance
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 96;   // 89 payload bits padded to bytes

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COVARIANCE = 2'd3;

  // register reset values
  localparam logic [WEIGHT_W-1:0]  RST_SMOOTH_WEIGHT    = 10'd660;
  localparam logic [NOISE_W-1:0]   RST_PROCESS_NOISE    = 24'd168;
  localparam logic [NOISE_W-1:0]   RST_MEASURE_NOISE    = 24'd1677722;
  localparam logic [COV_CFG_W-1:0] RST_START_COVARIANCE = 28'd16777216;

  // arithmetic constants
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 10'd1000;
  localparam logic [GAIN_W-1:0]   ONE_Q24     = 25'd16777216;
  localparam int                  Q24_SHIFT   = 24;

  // serial multiplier: signed multiplicand, unsigned multiplier, one bit per cycle
  localparam int MC_W       = 34;
  localparam int MP_W       = GAIN_W;
  localparam int PROD_W     = MC_W + MP_W;
  localparam int MUL_STEPS  = MP_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

  // gain divider: restoring, one quotient bit per cycle
  localparam int GDIV_STEPS = GAIN_W;
  localparam int GDIV_CNT_W = $clog2(GDIV_STEPS);
  localparam int DEN_W      = COV_W + 1;
  localparam int GREM_W     = DEN_W + 1;

  // divide by the weight scale: one quotient bit per cycle
  localparam int                 NUM_W      = 44;
  localparam int                 MAG_W      = 41;  // |num| <= 1000 * 2^31
  localparam int                 CDIV_STEPS = Q16_W;
  localparam int                 CDIV_CNT_W = $clog2(CDIV_STEPS);
  localparam int                 CREM_W     = 10;
  localparam logic [CREM_W:0]    LP_DIVISOR = 11'd1000;

endpackage

`default_nettype wire

/* rtl/lowpass_then_scalar_kalman_top.sv */
// top level: low-pass smoother feeding a scalar kalman filter (a = h = 1)
// depends on lpsk_pkg, lpsk_smul, lpsk_gdiv, lpsk_cdiv
//
//  port group | dir | beat contents
//  -----------+-----+------------------------------------------------------
//  in_*       | in  | tdata[15:0] sample
//  out_*      | out | tdata[31:0] estimate, [63:32] smoothed, [88:64] gain
//  cfg_*      | in  | write of register cfg_index with cfg_data, no wait
//
// an item passes from the in beat to the out beat through three serial
// phases of 25, 32 and 25 steps (bit-serial multipliers, the gain divider
// running alongside the first multiply, the divide by 1000), each with a start
// and a finish state, plus the sum, difference and done states; in_tready rises
// at the edge that presents the out beat. rst_n is synchronous; it reloads the
// registers, clears the smoother and estimate and loads the covariance.
// in_tready is high whenever no item is in flight, also while a result waits
// on out_tready; a result finished while the previous one is still unread
// waits in place.
`default_nettype none

module lowpass_then_scalar_kalman_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lpsk_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [31:0] estimate, [63:32] smoothed, [88:64] gain, [95:89] zero
  output logic [lpsk_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [lpsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lpsk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lpsk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LP_GO,     // start low-pass multiplies and gain divide
    S_LP_RUN,
    S_SUM,       // add the two low-pass products
    S_DIV_GO,    // start divide by 1000
    S_DIV_RUN,
    S_DIFF,      // innovation z - x and its magnitude
    S_UPD_GO,    // start correction and covariance multiplies
    S_UPD_RUN,
    S_DONE       // write back state and present the beat
  } state_t;

  // configuration registers
  logic [WEIGHT_W-1:0]  weight_r;
  logic [NOISE_W-1:0]   q_noise_r;
  logic [NOISE_W-1:0]   r_noise_r;

  // filter state
  state_t               state_r;
  logic [Q16_W-1:0]     smooth_prev_r;
  logic [Q16_W-1:0]     est_prev_r;
  logic [COV_W-1:0]     cov_prev_r;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // per-item working registers
  logic signed [Q16_W-1:0] x_r;
  logic [WEIGHT_W-1:0]     w_r;
  logic [WEIGHT_W-1:0]     wc_r;
  logic [COV_W-1:0]        pp_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [Q16_W-1:0] z_r;
  logic                    dneg_r;
  logic [Q16_W:0]          dmag_r;

  // serial unit hookup
  logic                    mul_start;
  logic                    gdiv_start;
  logic                    cdiv_start;
  logic                    upd_sel;
  logic signed [MC_W-1:0]  mca_in, mcb_in;
  logic [MP_W-1:0]         mpa_in, mpb_in;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic                    mul_a_busy, mul_b_busy, gdiv_busy, cdiv_busy;
  logic [GAIN_W-1:0]       gdiv_gain;
  logic signed [Q16_W-1:0] cdiv_quo;

  // combinational helpers
  logic [WEIGHT_W-1:0]     w_eff;
  logic [COV_W:0]          pp_sum;
  logic [COV_W-1:0]        pp_sat;
  logic signed [Q16_W:0]   d_wide;
  logic [Q16_W:0]          corr;
  logic [Q16_W:0]          scorr;
  logic [Q16_W-1:0]        est_nxt;
  logic [COV_W-1:0]        cov_nxt;
  logic signed [Q16_W+1:0] est_wide;
  logic                    out_free;
  logic                    in_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    // weights above full scale act as full scale
    w_eff  = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
    // predicted covariance saturates at all ones
    pp_sum = {1'b0, cov_prev_r} + (COV_W + 1)'(q_noise_r);
    pp_sat = pp_sum[COV_W] ? '1 : pp_sum[COV_W-1:0];
    d_wide = {z_r[Q16_W-1], z_r} - {est_prev_r[Q16_W-1], est_prev_r};
    // correction magnitude is g*|d| >> 24, applied with the sign of d
    corr     = prod_a[Q24_SHIFT +: (Q16_W + 1)];
    scorr    = dneg_r ? (~corr + 1'b1) : corr;
    est_nxt  = est_prev_r + scorr[Q16_W-1:0];
    est_wide = {{2{est_prev_r[Q16_W-1]}}, est_prev_r} + {scorr[Q16_W], scorr};
    cov_nxt  = prod_b[Q24_SHIFT +: COV_W];
  end

  // operand steering: the two multipliers serve the low-pass, then the update
  always_comb begin
    mul_start  = (state_r == S_LP_GO) || (state_r == S_UPD_GO);
    gdiv_start = (state_r == S_LP_GO);
    cdiv_start = (state_r == S_DIV_GO);
    upd_sel    = (state_r == S_UPD_GO);
    if (upd_sel) begin
      mca_in = MC_W'({1'b0, dmag_r});
      mpa_in = gain_r;
      mcb_in = MC_W'(pp_r);
      mpb_in = ONE_Q24 - gain_r;
    end else begin
      mca_in = MC_W'(x_r);
      mpa_in = MP_W'(w_r);
      mcb_in = MC_W'(signed'(smooth_prev_r));
      mpb_in = MP_W'(wc_r);
    end
  end

  lpsk_smul u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mca_in),
    .mplier (mpa_in),
    .busy   (mul_a_busy),
    .prod   (prod_a)
  );

  lpsk_smul u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mcb_in),
    .mplier (mpb_in),
    .busy   (mul_b_busy),
    .prod   (prod_b)
  );

  lpsk_gdiv u_gdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gdiv_start),
    .pp    (pp_r),
    .r     (r_noise_r),
    .busy  (gdiv_busy),
    .gain  (gdiv_gain)
  );

  lpsk_cdiv u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cdiv_start),
    .num   (num_r),
    .busy  (cdiv_busy),
    .quo   (cdiv_quo)
  );

  // sequencer, filter state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      weight_r      <= RST_SMOOTH_WEIGHT;
      q_noise_r     <= RST_PROCESS_NOISE;
      r_noise_r     <= RST_MEASURE_NOISE;
      smooth_prev_r <= '0;
      est_prev_r    <= '0;
      cov_prev_r    <= COV_W'(RST_START_COVARIANCE);
      out_tvalid_r  <= 1'b0;
    end else begin
      // a beat presented in S_DONE takes over the taken one
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      // register writes; start_covariance also reloads the covariance
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SMOOTH_WEIGHT:    weight_r   <= cfg_data[WEIGHT_W-1:0];
          REG_PROCESS_NOISE:    q_noise_r  <= cfg_data[NOISE_W-1:0];
          REG_MEASURE_NOISE:    r_noise_r  <= cfg_data[NOISE_W-1:0];
          REG_START_COVARIANCE: cov_prev_r <= COV_W'(cfg_data[COV_CFG_W-1:0]);
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            state_r <= S_LP_GO;
          end
        end
        S_LP_GO:  state_r <= S_LP_RUN;
        S_LP_RUN: begin
          if (!mul_a_busy && !mul_b_busy && !gdiv_busy) begin
            state_r <= S_SUM;
          end
        end
        S_SUM:    state_r <= S_DIV_GO;
        S_DIV_GO: state_r <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (!cdiv_busy) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF:   state_r <= S_UPD_GO;
        S_UPD_GO: state_r <= S_UPD_RUN;
        S_UPD_RUN: begin
          if (!mul_a_busy && !mul_b_busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold here until the previous beat is taken
          if (out_free) begin
            smooth_prev_r <= z_r;
            est_prev_r    <= est_nxt;
            cov_prev_r    <= cov_nxt;
            out_tvalid_r  <= 1'b1;
            out_tdata_r   <= {(OUT_DATA_W - GAIN_W - 2 * Q16_W)'(0), gain_r, z_r, est_nxt};
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // per-item data path registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_r  <= {in_tdata, 16'b0};
      w_r  <= w_eff;
      wc_r <= WEIGHT_FULL - w_eff;
      pp_r <= pp_sat;
    end
    if (state_r == S_SUM) begin
      num_r  <= prod_a[NUM_W-1:0] + prod_b[NUM_W-1:0];
      gain_r <= gdiv_gain;
    end
    if (state_r == S_DIV_RUN && !cdiv_busy) begin
      z_r <= cdiv_quo;
    end
    if (state_r == S_DIFF) begin
      dneg_r <= d_wide[Q16_W];
      dmag_r <= d_wide[Q16_W] ? (~d_wide + 1'b1) : d_wide;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // gain never exceeds one
  a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (gain_r <= ONE_Q24))
    else $error("kalman gain above one");

  // new estimate lies between the old estimate and the measurement
  a_est_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |->
      (dneg_r ? (est_wide <= (Q16_W + 2)'(signed'(est_prev_r)) &&
                 est_wide >= (Q16_W + 2)'(z_r))
              : (est_wide >= (Q16_W + 2)'(signed'(est_prev_r)) &&
                 est_wide <= (Q16_W + 2)'(z_r))))
    else $error("estimate left the interval of old estimate and measurement");

  // the update step never raises the predicted covariance
  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (cov_nxt <= pp_r))
    else $error("covariance grew in the update step");

  // no item taken while any serial unit is running
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_a_busy || mul_b_busy || gdiv_busy || cdiv_busy) |-> !in_tready)
    else $error("input ready while a serial unit is busy");

endmodule

`default_nettype wire

/* rtl/lpsk_smul.sv */
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
// depends on lpsk_pkg
`default_nettype none

module lpsk_smul (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [lpsk_pkg::MC_W-1:0] mcand,
  input  wire logic [lpsk_pkg::MP_W-1:0]        mplier,
  output logic                                  busy,
  output logic signed [lpsk_pkg::PROD_W-1:0]    prod
);
  import lpsk_pkg::*;

  logic                 busy_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic signed [MC_W-1:0] mc_r;
  logic signed [MC_W-1:0] hi_r;
  logic [MP_W-1:0]        lo_r;

  logic signed [MC_W:0]   addend;
  logic signed [MC_W:0]   sum;

  // add the multiplicand on a set low bit, then shift the whole product right
  always_comb begin
    addend = lo_r[0] ? {mc_r[MC_W-1], mc_r} : '0;
    sum    = {hi_r[MC_W-1], hi_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r <= mcand;
      hi_r <= '0;
      lo_r <= mplier;
    end else if (busy_r) begin
      hi_r <= sum[MC_W:1];
      lo_r <= {sum[0], lo_r[MP_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

/* rtl/lpsk_gdiv.sv */
// radix-2 restoring divider for the kalman gain g = p' * 2^24 / (p' + r)
// depends on lpsk_pkg
`default_nettype none

module lpsk_gdiv (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [lpsk_pkg::COV_W-1:0]       pp,
  input  wire logic [lpsk_pkg::NOISE_W-1:0]     r,
  output logic                                  busy,
  output logic [lpsk_pkg::GAIN_W-1:0]           gain
);
  import lpsk_pkg::*;

  logic                  busy_r;
  logic                  first_r;
  logic [GDIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]      den_r;
  logic [GREM_W-1:0]     rem_r;
  logic [GAIN_W-1:0]     q_r;
  logic                  zero_r;

  logic [GREM_W-1:0] trial;
  logic [GREM_W-1:0] diff;
  logic              ge;

  // first step compares p' itself (gain of one when r is zero), later steps shift
  always_comb begin
    trial = first_r ? rem_r : {rem_r[GREM_W-2:0], 1'b0};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == GDIV_CNT_W'(GDIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= {1'b0, pp} + DEN_W'(r);
      rem_r   <= GREM_W'(pp);
      q_r     <= '0;
      first_r <= 1'b1;
      zero_r  <= (pp == '0) && (r == '0);
    end else if (busy_r) begin
      first_r <= 1'b0;
      rem_r   <= ge ? diff : trial;
      q_r     <= {q_r[GAIN_W-2:0], ge};
    end
  end

  // zero denominator gives zero gain
  assign busy = busy_r;
  assign gain = zero_r ? '0 : q_r;

endmodule

`default_nettype wire

/* rtl/lpsk_cdiv.sv */
// bit-serial divide of the signed low-pass sum by 1000, truncating toward zero
// depends on lpsk_pkg
`default_nettype none

module lpsk_cdiv (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [lpsk_pkg::NUM_W-1:0] num,
  output logic                                  busy,
  output logic signed [lpsk_pkg::Q16_W-1:0]     quo
);
  import lpsk_pkg::*;

  logic                  busy_r;
  logic [CDIV_CNT_W-1:0] cnt_r;
  logic                  neg_r;
  logic [CREM_W-1:0]     rem_r;
  logic [Q16_W-1:0]      sh_r;   // dividend bits shift out, quotient bits shift in

  logic [NUM_W-1:0]  mag;
  logic [CREM_W:0]   trial;
  logic [CREM_W:0]   diff;
  logic              ge;

  always_comb begin
    mag   = num[NUM_W-1] ? (~num + 1'b1) : num;
    trial = {rem_r, sh_r[Q16_W-1]};
    diff  = trial - LP_DIVISOR;
    ge    = (trial >= LP_DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CDIV_CNT_W'(CDIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // top bits of the magnitude stay below 1000, so they seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      rem_r <= CREM_W'(mag[MAG_W-1:Q16_W]);
      sh_r  <= mag[Q16_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[CREM_W-1:0] : trial[CREM_W-1:0];
      sh_r  <= {sh_r[Q16_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? (~sh_r + 1'b1) : sh_r;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for lowpass_then_scalar_kalman_top: directed rows, then random phases
// depends on lpsk_pkg and the rtl top; results are predicted in-bench and checked in order

module testbench;
  import lpsk_pkg::*;

  // one result beat, split into its fields
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [Q16_W-1:0]  smoothed;
    logic [Q16_W-1:0]  estimate;
  } kal_result_t;

  // one row of the directed part: a register write or a sample beat
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [SAMPLE_W-1:0]   sample;
    bit                    known;      // result typed in by hand
    kal_result_t           known_res;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  wire                   in_tready;
  logic [SAMPLE_W-1:0]   in_tdata   = '0;   // [15:0] sample
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] out_tdata;         // [31:0] estimate, [63:32] smoothed, [88:64] gain
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor copy of the registers and of the filter state
  logic [WEIGHT_W-1:0]  weight_reg;
  logic [NOISE_W-1:0]   proc_noise_reg;
  logic [NOISE_W-1:0]   meas_noise_reg;
  logic [Q16_W-1:0]     smooth_state;
  logic [Q16_W-1:0]     est_state;
  logic [COV_W-1:0]     cov_state;

  kal_result_t         pending_results[$];
  stim_row_t           stim_rows[$];
  int                  fail_count     = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_left      = 0;   // long receiver hold-off, counted by the receiver
  logic [SAMPLE_W-1:0] last_sample    = '0;

  lowpass_then_scalar_kalman_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("lowpass_then_scalar_kalman_top test failed");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // one filter step: low-pass, predict, gain, update; advances the predictor state
  function automatic kal_result_t kalman_step(input logic [SAMPLE_W-1:0] s);
    longint            sx, x, w, yprev, z, xprev, d, corr, xnew;
    longint unsigned   pp, den, g, mag, pnew;
    kal_result_t       r;
    sx = $signed(s);
    x  = sx * 65536;
    // weights above full scale behave as full scale
    w = (weight_reg > WEIGHT_FULL) ? longint'(WEIGHT_FULL) : longint'(weight_reg);
    yprev = $signed(smooth_state);
    z = (w * x + (1000 - w) * yprev) / 1000;   // truncates toward zero
    smooth_state = z[31:0];

    pp = {32'd0, cov_state} + {40'd0, proc_noise_reg};
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    den = pp + {40'd0, meas_noise_reg};
    // zero denominator gives zero gain, so estimate and covariance hold
    g = (den == 0) ? 64'd0 : (pp << Q24_SHIFT) / den;
    if (g > ONE_Q24) g = ONE_Q24;

    xprev = $signed(est_state);
    d     = z - xprev;
    mag   = (d < 0) ? -d : d;
    corr  = longint'((g * mag) >> Q24_SHIFT);
    xnew  = (d < 0) ? xprev - corr : xprev + corr;
    est_state = xnew[31:0];

    pnew = ((ONE_Q24 - g) * pp) >> Q24_SHIFT;
    cov_state = pnew[31:0];

    r.estimate = est_state;
    r.smoothed = smooth_state;
    r.gain     = g[GAIN_W-1:0];
    return r;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{is_write: 1'b1, reg_idx: idx, reg_val: val, sample: '0, known: 1'b0,
            known_res: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] s);
    stim_row_t row;
    row = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, sample: s, known: 1'b0,
            known_res: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic [SAMPLE_W-1:0] s, input logic [Q16_W-1:0] est,
                                    input logic [Q16_W-1:0] sm, input logic [GAIN_W-1:0] g);
    stim_row_t row;
    row = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, sample: s, known: 1'b1,
            known_res: '{gain: g, smoothed: sm, estimate: est}};
    stim_rows.push_back(row);
  endfunction

  // random register values, extremes weighted in
  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(WEIGHT_FULL);
      2:       return CFG_DATA_W'($urandom_range(1023, 1001));   // above full scale
      default: return CFG_DATA_W'($urandom_range(1000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_proc_noise();
    case ($urandom_range(4))
      0:       return '0;
      1:       return CFG_DATA_W'(24'hFF_FFFF);
      2:       return CFG_DATA_W'($urandom_range(255));
      default: return CFG_DATA_W'($urandom_range(24'hFF_FFFF));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_meas_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(24'hFF_FFFF);
      default: return CFG_DATA_W'($urandom_range(24'hFF_FFFF, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_start_cov();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 28'hFFF_FFFF;
      default: return CFG_DATA_W'($urandom_range(28'hA00_0000));
    endcase
  endfunction

  // random samples: extremes, held runs so the filter settles, and plain noise
  function automatic logic [SAMPLE_W-1:0] next_sample();
    case ($urandom_range(9))
      0:       last_sample = 16'h7FFF;
      1:       last_sample = 16'h8000;
      2, 3:    ;                                    // repeat the previous value
      4:       last_sample = last_sample + SAMPLE_W'($urandom_range(64)) - 16'd32;
      default: last_sample = SAMPLE_W'($urandom_range(16'hFFFF));
    endcase
    return last_sample;
  endfunction

  // register write; entered and left just after a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SMOOTH_WEIGHT: weight_reg     = val[WEIGHT_W-1:0];
      REG_PROCESS_NOISE: proc_noise_reg = val[NOISE_W-1:0];
      REG_MEASURE_NOISE: meas_noise_reg = val[NOISE_W-1:0];
      REG_START_COVARIANCE: begin
        // the write also reloads the running covariance
        cov_state = {4'd0, val[COV_CFG_W-1:0]};
      end
      default: ;
    endcase
  endtask

  // offer one sample beat, with an optional sender gap first
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit known,
                             input kal_result_t known_res);
    kal_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(120, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat taken at this edge: predict against the state as it stands now
    predicted = kalman_step(s);
    pending_results.push_back(known ? known_res : predicted);
    @(negedge clk);
  endtask

  // stop offering and wait until every result is back, so the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: every out beat against the oldest prediction
  always @(posedge clk) begin : result_check
    kal_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("out beat %h with nothing pending", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.estimate || out_tdata[63:32] !== want.smoothed ||
            out_tdata[88:64] !== want.gain) begin
          note_failure($sformatf("estimate %h (want %h) smoothed %h (want %h) gain %h (want %h)",
                                 out_tdata[31:0], want.estimate, out_tdata[63:32],
                                 want.smoothed, out_tdata[88:64], want.gain));
        end
      end
    end
  end

  initial begin : main_flow
    int idle_send[4];
    int idle_recv[4];
    int waited;
    // phases: no idling, sender gaps, receiver stalls, both
    idle_send = '{0, 52, 0, 32};
    idle_recv = '{0, 0, 52, 32};

    // predictor state after reset
    weight_reg     = RST_SMOOTH_WEIGHT;
    proc_noise_reg = RST_PROCESS_NOISE;
    meas_noise_reg = RST_MEASURE_NOISE;
    smooth_state   = '0;
    est_state      = '0;
    cov_state      = {4'd0, RST_START_COVARIANCE};

    // reset defaults with the sample extremes
    add_sample(16'h0000);
    add_sample(16'h7FFF);
    add_sample(16'h8000);
    add_sample(16'h0001);
    add_sample(16'hFFFF);
    // weight above full scale and zero measurement noise: sample passes through, gain is one
    add_write(REG_SMOOTH_WEIGHT, 28'd1023);
    add_write(REG_MEASURE_NOISE, 28'd0);
    add_known(16'h7FFF, 32'h7FFF_0000, 32'h7FFF_0000, ONE_Q24);
    add_known(16'h8000, 32'h8000_0000, 32'h8000_0000, ONE_Q24);
    add_known(16'h5555, 32'h5555_0000, 32'h5555_0000, ONE_Q24);
    // zero weight: the smoother holds its last value
    add_write(REG_SMOOTH_WEIGHT, 28'd0);
    add_known(16'hFFFF, 32'h5555_0000, 32'h5555_0000, ONE_Q24);
    // zero covariance, zero noise: zero denominator, estimate frozen
    add_write(REG_PROCESS_NOISE, 28'd0);
    add_write(REG_START_COVARIANCE, 28'd0);
    add_write(REG_SMOOTH_WEIGHT, 28'd1000);
    add_known(16'h1234, 32'h5555_0000, 32'h1234_0000, '0);
    add_known(16'h8000, 32'h5555_0000, 32'h8000_0000, '0);
    // register maxima; weight written with junk above its ten bits
    add_write(REG_PROCESS_NOISE, 28'hFF_FFFF);
    add_write(REG_MEASURE_NOISE, 28'hFF_FFFF);
    add_write(REG_START_COVARIANCE, 28'hFFF_FFFF);
    add_write(REG_SMOOTH_WEIGHT, 28'hABC_D1F4);
    add_sample(16'h7FFF);
    add_sample(16'h8000);
    add_sample(16'h0000);
    add_sample(16'h3039);
    // smallest nonzero settings
    add_write(REG_SMOOTH_WEIGHT, 28'd1);
    add_write(REG_PROCESS_NOISE, 28'd1);
    add_write(REG_MEASURE_NOISE, 28'd1);
    add_write(REG_START_COVARIANCE, 28'd1);
    add_sample(16'h7FFF);
    add_sample(16'h8001);
    add_sample(16'h00FF);
    // back to the reset settings
    add_write(REG_SMOOTH_WEIGHT, CFG_DATA_W'(RST_SMOOTH_WEIGHT));
    add_write(REG_PROCESS_NOISE, CFG_DATA_W'(RST_PROCESS_NOISE));
    add_write(REG_MEASURE_NOISE, CFG_DATA_W'(RST_MEASURE_NOISE));
    add_write(REG_START_COVARIANCE, CFG_DATA_W'(RST_START_COVARIANCE));
    add_sample(16'h4000);
    add_sample(16'hC000);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_write) begin
        drain();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        push_sample(stim_rows[i].sample, stim_rows[i].known, stim_rows[i].known_res);
      end
    end

    // random part: each idling mode twice, fresh settings per phase
    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(REG_SMOOTH_WEIGHT, pick_weight());
      write_reg(REG_PROCESS_NOISE, pick_proc_noise());
      write_reg(REG_MEASURE_NOISE, pick_meas_noise());
      write_reg(REG_START_COVARIANCE, pick_start_cov());
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      repeat (85) push_sample(next_sample(), 1'b0, '0);
    end

    // back-pressure: receiver holds off while beats keep coming, block fills and stalls
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    repeat (45) push_sample(next_sample(), 1'b0, '0);

    // wind-down: bounded wait for the last results, then a quiet stretch
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never came", pending_results.size()));

    if (fail_count == 0) begin
      $display("lowpass_then_scalar_kalman_top test passed");
    end else begin
      $display("lowpass_then_scalar_kalman_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lpsk_pkg.sv
rtl/lpsk_smul.sv
rtl/lpsk_gdiv.sv
rtl/lpsk_cdiv.sv
rtl/lowpass_then_scalar_kalman_top.sv
dv/testbench.sv
